@@ rtl/usd_pkg.sv @@
`timescale 1ns / 1ps
// Shared types and constants of the UTF-8 stream decoder.
// No dependencies.
package usd_pkg;

    localparam int unsigned CP_W   = 21;
    localparam int unsigned BYTE_W = 8;
    localparam int unsigned CNT_W  = 3;

    typedef logic [CP_W-1:0]   cp_t;
    typedef logic [BYTE_W-1:0] byte_t;
    typedef logic [CNT_W-1:0]  cnt_t;
    typedef logic [1:0]        seq_t;

    localparam cp_t   REPL_CP    = cp_t'(24'h00FFFD);
    localparam byte_t LEAD2_MASK = 8'h1F;
    localparam byte_t LEAD3_MASK = 8'h0F;
    localparam byte_t LEAD4_MASK = 8'h07;

endpackage

@@ rtl/utf8_stream_decoder_unit.sv @@
`timescale 1ns / 1ps
// Top level of the UTF-8 stream decoder: input register, decode, result run.
// Depends on usd_pkg.
//
// An accepted byte passes the input register and then the result register before its first result.
// Throughput: one byte per cycle while each byte gives at most one result and the output
// is not stalled; a byte giving n results holds the result register until all n are taken.
// Bytes giving no result pass through without waiting on the output.
// Reset (rst_n low, asynchronous) empties both stages and clears any open sequence.
module utf8_stream_decoder_unit
    import usd_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  data_byte,
    input  logic        end_of_input,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [20:0] code_point,
    output logic        is_replacement,
    output logic        last_of_run,
    output logic        stream_finished
);

    logic  s1_valid_reg, s1_valid_next;
    byte_t s1_byte_reg;
    logic  s1_eoi_reg;

    cp_t   pv_reg, pv_next;
    seq_t  need_reg, need_next;
    seq_t  taken_reg, taken_next;

    cnt_t  rem_reg, rem_next;
    cp_t   last_cp_reg, last_cp_next;
    logic  last_rep_reg, last_rep_next;
    logic  fin_reg, fin_next;

    cp_t   pv_shift;
    cnt_t  n_bad;
    logic  cont_emit, lead_ascii, lead_bad, eoi_emit, as_lead;
    cnt_t  cnt;
    logic  run_free, advance;

    // decode
    always_comb
    begin
        pv_next    = pv_reg;
        need_next  = need_reg;
        taken_next = taken_reg;
        n_bad      = '0;
        cont_emit  = 1'b0;
        lead_ascii = 1'b0;
        lead_bad   = 1'b0;
        eoi_emit   = 1'b0;
        as_lead    = 1'b1;
        pv_shift   = {pv_reg[CP_W-7:0], s1_byte_reg[5:0]};

        if (need_reg != 2'd0)
        begin
            if (s1_byte_reg[7:6] == 2'b10)
            begin
                as_lead   = 1'b0;
                pv_next   = pv_shift;
                need_next = need_reg - 2'd1;
                if (need_reg == 2'd1)
                begin
                    cont_emit  = 1'b1;
                    pv_next    = '0;
                    taken_next = '0;
                end
                else
                begin
                    taken_next = taken_reg + 2'd1;
                end
            end
            else
            begin
                n_bad      = cnt_t'(taken_reg) + cnt_t'(1);
                pv_next    = '0;
                need_next  = '0;
                taken_next = '0;
            end
        end

        if (as_lead)
        begin
            case (s1_byte_reg) inside
                [8'h00:8'h7F]:
                    lead_ascii = 1'b1;
                [8'hC0:8'hDF]:
                begin
                    pv_next    = cp_t'(s1_byte_reg & LEAD2_MASK);
                    need_next  = 2'd1;
                    taken_next = '0;
                end
                [8'hE0:8'hEF]:
                begin
                    pv_next    = cp_t'(s1_byte_reg & LEAD3_MASK);
                    need_next  = 2'd2;
                    taken_next = '0;
                end
                [8'hF0:8'hF7]:
                begin
                    pv_next    = cp_t'(s1_byte_reg & LEAD4_MASK);
                    need_next  = 2'd3;
                    taken_next = '0;
                end
                default:
                    lead_bad = 1'b1;
            endcase
        end

        if (s1_eoi_reg)
        begin
            eoi_emit   = (need_next != 2'd0);
            pv_next    = '0;
            need_next  = '0;
            taken_next = '0;
        end

        cnt = n_bad + cnt_t'(cont_emit) + cnt_t'(lead_ascii) + cnt_t'(lead_bad)
            + cnt_t'(eoi_emit);
    end

    // handshake
    assign run_free      = (rem_reg == cnt_t'(0)) || ((rem_reg == cnt_t'(1)) && out_ready);
    assign advance       = s1_valid_reg && ((cnt == cnt_t'(0)) || run_free);
    assign in_ready      = !s1_valid_reg || advance;
    assign s1_valid_next = (in_valid && in_ready) || (s1_valid_reg && !advance);

    // result run
    always_comb
    begin
        rem_next      = rem_reg;
        last_cp_next  = last_cp_reg;
        last_rep_next = last_rep_reg;
        fin_next      = fin_reg;
        if (out_valid && out_ready)
        begin
            rem_next = rem_reg - cnt_t'(1);
        end
        if (advance && (cnt != cnt_t'(0)))
        begin
            rem_next = cnt;
            fin_next = s1_eoi_reg;
            if (eoi_emit)
            begin
                last_cp_next  = REPL_CP;
                last_rep_next = 1'b1;
            end
            else if (lead_ascii)
            begin
                last_cp_next  = cp_t'(s1_byte_reg);
                last_rep_next = 1'b0;
            end
            else if (cont_emit)
            begin
                last_cp_next  = pv_shift;
                last_rep_next = 1'b0;
            end
            else
            begin
                last_cp_next  = REPL_CP;
                last_rep_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            pv_reg       <= '0;
            need_reg     <= '0;
            taken_reg    <= '0;
            rem_reg      <= '0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
            rem_reg      <= rem_next;
            if (advance)
            begin
                pv_reg    <= pv_next;
                need_reg  <= need_next;
                taken_reg <= taken_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            s1_byte_reg <= data_byte;
            s1_eoi_reg  <= end_of_input;
        end
        last_cp_reg  <= last_cp_next;
        last_rep_reg <= last_rep_next;
        fin_reg      <= fin_next;
    end

    assign out_valid       = (rem_reg != cnt_t'(0));
    assign last_of_run     = (rem_reg == cnt_t'(1));
    assign code_point      = last_of_run ? last_cp_reg : REPL_CP;
    assign is_replacement  = last_of_run ? last_rep_reg : 1'b1;
    assign stream_finished = last_of_run && fin_reg;

endmodule

@@ rtl/usd_checker.sv @@
`timescale 1ns / 1ps
// Port-level checks on the UTF-8 stream decoder, bound to the top level.
// Depends on usd_pkg and utf8_stream_decoder_unit.
module usd_checker
    import usd_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    input logic        out_valid,
    input logic        out_ready,
    input logic [20:0] code_point,
    input logic        is_replacement,
    input logic        last_of_run,
    input logic        stream_finished
);

    // hold a stalled result
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(code_point)
        && $stable(last_of_run))
        else $error("result changed while stalled");

    a_fin_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && stream_finished |-> last_of_run)
        else $error("stream end not on last item of a run");

    a_mid_repl: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !last_of_run |-> is_replacement && (code_point == REPL_CP))
        else $error("non-final item of a run is not a replacement");

    a_repl_cp: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && is_replacement |-> (code_point == REPL_CP))
        else $error("replacement with wrong code point");

    a_run_cont: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_ready && !last_of_run |=> out_valid)
        else $error("run broken before its last item");

endmodule

bind utf8_stream_decoder_unit usd_checker u_usd_checker (.*);
